// File: hw/rtl/dasd_pkg.sv
// ----------------------------------------------------------------------------
// dasd_pkg
// types, codes and calendar helpers shared by the date adder modules
// ----------------------------------------------------------------------------
package dasd_pkg;

  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_DATE   = 2'd1;
  localparam logic [1:0] ST_YEAR_RANGE = 2'd2;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_DEC = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_CYC,
    S_STEP
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MOD,
    OP_CYC,
    OP_ADJ,
    OP_STEP,
    OP_DONE_OK,
    OP_DONE_BAD,
    OP_DONE_OOR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic mod_last;
    logic date_bad;
    logic cyc_due;
    logic year_oor;
    logic month_due;
  } flags_t;

  // year mod 400 residue plus low year bits give the leap rule
  function automatic logic is_leap(input logic [1:0] ylo, input logic [8:0] r400);
    logic cent;
    cent = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return (ylo == 2'd0) && !cent;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      MON_FEB:                                   len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/dasd_ctrl.sv
// ----------------------------------------------------------------------------
// dasd_ctrl
// sequencer for the date adder: residue setup, check, 400-year and month steps
// ----------------------------------------------------------------------------
module dasd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  dasd_pkg::flags_t flags,
  output dasd_pkg::cmd_t  cmd
);

  dasd_pkg::state_t state_r;
  dasd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dasd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dasd_pkg::S_IDLE: begin
        if (start) state_nxt = dasd_pkg::S_MOD;
      end
      dasd_pkg::S_MOD: begin
        if (flags.mod_last) state_nxt = dasd_pkg::S_CHECK;
      end
      dasd_pkg::S_CHECK: begin
        state_nxt = flags.date_bad ? dasd_pkg::S_IDLE : dasd_pkg::S_CYC;
      end
      dasd_pkg::S_CYC: begin
        if (flags.year_oor) state_nxt = dasd_pkg::S_IDLE;
        else if (!flags.cyc_due) state_nxt = dasd_pkg::S_STEP;
      end
      dasd_pkg::S_STEP: begin
        if (flags.year_oor || !flags.month_due) state_nxt = dasd_pkg::S_IDLE;
      end
      default: state_nxt = dasd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = dasd_pkg::OP_NONE;
    unique case (state_r)
      dasd_pkg::S_IDLE: begin
        if (start) cmd.op = dasd_pkg::OP_LOAD;
      end
      dasd_pkg::S_MOD: begin
        cmd.op = dasd_pkg::OP_MOD;
      end
      dasd_pkg::S_CHECK: begin
        if (flags.date_bad) cmd.op = dasd_pkg::OP_DONE_BAD;
      end
      dasd_pkg::S_CYC: begin
        if (flags.year_oor) cmd.op = dasd_pkg::OP_DONE_OOR;
        else if (flags.cyc_due) cmd.op = dasd_pkg::OP_CYC;
        else cmd.op = dasd_pkg::OP_ADJ;
      end
      dasd_pkg::S_STEP: begin
        if (flags.year_oor) cmd.op = dasd_pkg::OP_DONE_OOR;
        else if (flags.month_due) cmd.op = dasd_pkg::OP_STEP;
        else cmd.op = dasd_pkg::OP_DONE_OK;
      end
      default: cmd.op = dasd_pkg::OP_NONE;
    endcase
  end

  assign busy = (state_r != dasd_pkg::S_IDLE);

endmodule

// File: hw/rtl/dasd_dp.sv
// ----------------------------------------------------------------------------
// dasd_dp
// datapath for the date adder: year residue, day and month counters, result
// ----------------------------------------------------------------------------
module dasd_dp #(
  parameter int YEAR_BITS   = 16,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dasd_pkg::cmd_t         cmd,
  output dasd_pkg::flags_t       flags,
  input  logic [YEAR_BITS-1:0]   in_year_in,
  input  logic [3:0]             in_month_in,
  input  logic [4:0]             in_day_in,
  input  logic [OFFSET_BITS-1:0] in_day_offset,
  output logic                   out_valid,
  output logic [YEAR_BITS-1:0]   out_year_out,
  output logic [3:0]             out_month_out,
  output logic [4:0]             out_day_out,
  output logic [1:0]             out_status
);

  localparam int YW   = YEAR_BITS + 2;
  localparam int DW   = OFFSET_BITS + 2;
  localparam int CMPW = (DW > 20) ? DW : 20;
  localparam int QS   = YEAR_BITS + 9;
  localparam int PW   = 2 * YEAR_BITS + 1;
  localparam int QW   = YEAR_BITS - 8;

  // reciprocal of 400 scaled by 2^QS, exact quotient for every year value
  localparam logic [63:0] RECIP = ((64'd1 << QS) + 64'd399) / 64'd400;

  localparam logic signed [CMPW-1:0] CYC_POS = CMPW'(dasd_pkg::CYCLE_DAYS);
  localparam logic signed [CMPW-1:0] CYC_NEG = -CYC_POS;
  localparam logic signed [YW-1:0]   CYC_YRS = YW'(dasd_pkg::CYCLE_YEARS);

  logic [YEAR_BITS-1:0] yin_r;
  logic [3:0]           min_r;
  logic [4:0]           din_r;
  logic                 cnt_r, cnt_nxt;
  logic [QW-1:0]        quo_r, quo_nxt;
  logic [8:0]           r400_r, r400_nxt;
  logic signed [YW-1:0] year_r, year_nxt;
  logic [3:0]           month_r, month_nxt;
  logic signed [DW-1:0] day_r, day_nxt;

  logic                 out_valid_r;
  logic [YEAR_BITS-1:0] year_out_r;
  logic [3:0]           month_out_r;
  logic [4:0]           day_out_r;
  logic [1:0]           status_r;

  logic                   leap;
  logic [4:0]             cur_len;
  logic [4:0]             prev_len;
  logic [3:0]             month_dec;
  logic signed [CMPW-1:0] day_ext;
  logic [PW-1:0]          quo_prod;
  logic [YEAR_BITS-1:0]   quo_mul;
  logic                   day_hi;
  logic                   day_lo;

  assign leap      = dasd_pkg::is_leap(year_r[1:0], r400_r);
  assign cur_len   = dasd_pkg::month_len(month_r, leap);
  assign month_dec = month_r - 4'd1;
  assign prev_len  = dasd_pkg::month_len(month_dec, leap);
  assign day_ext   = $signed({{(CMPW - DW){day_r[DW-1]}}, day_r});
  assign quo_prod  = PW'(yin_r) * PW'(RECIP);
  assign quo_mul   = YEAR_BITS'(quo_r) * YEAR_BITS'(dasd_pkg::CYCLE_YEARS);
  assign day_hi    = day_r > $signed(DW'(cur_len));
  assign day_lo    = day_r[DW-1] || (day_r == '0);

  assign flags.mod_last  = (cnt_r == 1'b0);
  assign flags.date_bad  = (min_r == 4'd0) || (min_r > dasd_pkg::MON_DEC) || (din_r == 5'd0) ||
                           (din_r > cur_len);
  assign flags.cyc_due   = (day_ext >= CYC_POS) || (day_ext <= CYC_NEG);
  assign flags.year_oor  = year_r[YW-1] || (year_r[YW-2:YEAR_BITS] != '0);
  assign flags.month_due = day_hi || day_lo;

  always_comb begin
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    r400_nxt  = r400_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    case (cmd.op)
      dasd_pkg::OP_LOAD: begin
        cnt_nxt   = 1'b1;
        r400_nxt  = 9'd0;
        year_nxt  = $signed(YW'(in_year_in));
        month_nxt = in_month_in;
        day_nxt   = $signed({{(DW - OFFSET_BITS){in_day_offset[OFFSET_BITS-1]}}, in_day_offset});
      end
      dasd_pkg::OP_MOD: begin
        cnt_nxt = 1'b0;
        if (cnt_r) begin
          quo_nxt = quo_prod[PW-1:QS];
        end else begin
          r400_nxt = 9'(yin_r - quo_mul);
        end
      end
      dasd_pkg::OP_CYC: begin
        if (day_ext >= CYC_POS) begin
          day_nxt  = DW'(day_ext - CYC_POS);
          year_nxt = year_r + CYC_YRS;
        end else begin
          day_nxt  = DW'(day_ext + CYC_POS);
          year_nxt = year_r - CYC_YRS;
        end
      end
      dasd_pkg::OP_ADJ: begin
        day_nxt = day_r + $signed(DW'(din_r));
      end
      dasd_pkg::OP_STEP: begin
        if (day_hi) begin
          day_nxt = day_r - $signed(DW'(cur_len));
          if (month_r == dasd_pkg::MON_DEC) begin
            month_nxt = dasd_pkg::MON_JAN;
            year_nxt  = year_r + YW'(1);
            r400_nxt  = (r400_r == 9'd399) ? 9'd0 : r400_r + 9'd1;
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end else begin
          if (month_r == dasd_pkg::MON_JAN) begin
            month_nxt = dasd_pkg::MON_DEC;
            year_nxt  = year_r - YW'(1);
            r400_nxt  = (r400_r == 9'd0) ? 9'd399 : r400_r - 9'd1;
            day_nxt   = day_r + $signed(DW'(5'd31));
          end else begin
            month_nxt = month_dec;
            day_nxt   = day_r + $signed(DW'(prev_len));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    quo_r   <= quo_nxt;
    r400_r  <= r400_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    if (cmd.op == dasd_pkg::OP_LOAD) begin
      yin_r <= in_year_in;
      min_r <= in_month_in;
      din_r <= in_day_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == dasd_pkg::OP_DONE_OK) || (cmd.op == dasd_pkg::OP_DONE_BAD) ||
                     (cmd.op == dasd_pkg::OP_DONE_OOR);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      dasd_pkg::OP_DONE_OK: begin
        year_out_r  <= year_r[YEAR_BITS-1:0];
        month_out_r <= month_r;
        day_out_r   <= day_r[4:0];
        status_r    <= dasd_pkg::ST_OK;
      end
      dasd_pkg::OP_DONE_BAD, dasd_pkg::OP_DONE_OOR: begin
        year_out_r  <= yin_r;
        month_out_r <= min_r;
        day_out_r   <= din_r;
        status_r    <= (cmd.op == dasd_pkg::OP_DONE_BAD) ? dasd_pkg::ST_BAD_DATE
                                                         : dasd_pkg::ST_YEAR_RANGE;
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_year_out  = year_out_r;
  assign out_month_out = month_out_r;
  assign out_day_out   = day_out_r;
  assign out_status    = status_r;

endmodule

// File: hw/rtl/date_add_signed_days_core.sv
// ----------------------------------------------------------------------------
// date_add_signed_days_core
// adds a signed day offset to a Gregorian date, one month per cycle
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It then forms
// the year mod 400 residue by reciprocal multiplication, checks the
// date, steps the offset by each whole 400-year span, adds the day of
// month, and crosses one month boundary per step until the day fits;
// the last step loads the result register. The result shows for exactly
// one cycle with out_valid; the receiver cannot stall, so it must take
// every transfer.
module date_add_signed_days_core #(
  parameter int YEAR_BITS   = 16,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [YEAR_BITS-1:0]   in_year_in,
  input  logic [3:0]             in_month_in,
  input  logic [4:0]             in_day_in,
  input  logic [OFFSET_BITS-1:0] in_day_offset,
  output logic                   out_valid,
  output logic [YEAR_BITS-1:0]   out_year_out,
  output logic [3:0]             out_month_out,
  output logic [4:0]             out_day_out,
  output logic [1:0]             out_status
);

  dasd_pkg::cmd_t   cmd;
  dasd_pkg::flags_t flags;

  dasd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  dasd_dp #(
    .YEAR_BITS   (YEAR_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .flags         (flags),
    .in_year_in    (in_year_in),
    .in_month_in   (in_month_in),
    .in_day_in     (in_day_in),
    .in_day_offset (in_day_offset),
    .out_valid     (out_valid),
    .out_year_out  (out_year_out),
    .out_month_out (out_month_out),
    .out_day_out   (out_day_out),
    .out_status    (out_status)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result transfer while still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dasd_pkg::ST_OK) |->
      (out_month_out != 4'd0) && (out_month_out <= dasd_pkg::MON_DEC) &&
      (out_day_out != 5'd0))
    else $error("ok result with malformed date");

endmodule
